### sv/gcq_pkg.sv
// Package: widths, register indexes and pipeline stage types for the gamma color quantizer.
`timescale 1ns / 1ps
package gcq_pkg;

  localparam int unsigned SUM_W       = 28;   // width of one accumulated sum
  localparam int unsigned CNT_W       = 13;   // width of the sample count register
  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned Q_W         = 16;   // quotient bits kept before saturation
  localparam int unsigned R_W         = 8;    // channel byte width
  localparam int unsigned D_W         = CNT_W + Q_W - 1;  // divisor pre-shifted for top bit
  localparam int unsigned CMP_W       = (SUM_W > D_W) ? SUM_W : D_W;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned CIDX_W      = 2;

  typedef enum logic [CIDX_W-1:0] {
    CfgGammaEnable = 2'd0,
    CfgSampleCount = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
  } pix_in_t;

  typedef struct packed {
    logic [R_W-1:0] red_byte;
    logic [R_W-1:0] green_byte;
    logic [R_W-1:0] blue_byte;
  } pix_out_t;

  // One channel inside the divider row
  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic             sat;
    logic [R_W-1:0]   lin;
  } div_ch_t;

  typedef struct packed {
    logic                     valid;
    logic                     gamma;
    logic [D_W-1:0]           dvs;
    div_ch_t [NUM_CH-1:0]     ch;
  } div_stage_t;

  // One channel inside the square root row
  typedef struct packed {
    logic [Q_W-1:0] rad;
    logic [Q_W:0]   root;
    logic           sat;
    logic [R_W-1:0] lin;
  } sqrt_ch_t;

  typedef struct packed {
    logic                  valid;
    logic                  gamma;
    logic [Q_W-1:0]        bitm;
    sqrt_ch_t [NUM_CH-1:0] ch;
  } sqrt_stage_t;

endpackage

### sv/gcq_div_cell.sv
// Divider cell: one restoring quotient bit per channel, divisor shifted on to the next cell.
`timescale 1ns / 1ps
module gcq_div_cell import gcq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  div_stage_t stage_i,
  output div_stage_t stage_o
);

  div_stage_t stage_d, stage_q;

  // Trial subtract of the divisor from each remainder
  always_comb begin
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] dvs_ext;
    logic [CMP_W-1:0] diff;
    stage_d     = stage_i;
    stage_d.dvs = stage_i.dvs >> 1;
    dvs_ext     = CMP_W'(stage_i.dvs);
    for (int c = 0; c < NUM_CH; c++) begin
      rem_ext = CMP_W'(stage_i.ch[c].rem);
      diff    = rem_ext - dvs_ext;
      if (rem_ext >= dvs_ext) begin
        stage_d.ch[c].rem = diff[SUM_W-1:0];
        stage_d.ch[c].quo = {stage_i.ch[c].quo[Q_W-2:0], 1'b1};
      end else begin
        stage_d.ch[c].quo = {stage_i.ch[c].quo[Q_W-2:0], 1'b0};
      end
    end
  end

  // Advance the stage; clear it under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### sv/gcq_sqrt_cell.sv
// Square root cell: one root bit per channel, trial bit shifted on to the next cell.
`timescale 1ns / 1ps
module gcq_sqrt_cell import gcq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  sqrt_stage_t stage_i,
  output sqrt_stage_t stage_o
);

  sqrt_stage_t stage_d, stage_q;

  // Try root plus bit against the radicand
  always_comb begin
    logic [Q_W:0] trial;
    stage_d      = stage_i;
    stage_d.bitm = stage_i.bitm >> 2;
    for (int c = 0; c < NUM_CH; c++) begin
      trial = stage_i.ch[c].root + {1'b0, stage_i.bitm};
      if ({1'b0, stage_i.ch[c].rad} >= trial) begin
        stage_d.ch[c].rad  = stage_i.ch[c].rad - trial[Q_W-1:0];
        stage_d.ch[c].root = (stage_i.ch[c].root >> 1) + {1'b0, stage_i.bitm};
      end else begin
        stage_d.ch[c].root = stage_i.ch[c].root >> 1;
      end
    end
  end

  // Advance the stage; clear it under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### sv/gamma_color_quantizer.sv
// Pipeline: entry stage, 16 divider cells, 8 square root cells, output register.
// Throughput: one item per cycle; the whole cell row advances together and
// halts only while the output register holds an item that is not taken.
// Reset: asynchronous, active low; empties the pipeline, gamma_enable = 1,
// sample_count = 1.
`timescale 1ns / 1ps
module gamma_color_quantizer import gcq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pix_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pix_out_t          out_data_o
);

  localparam int unsigned NDIV  = Q_W;
  localparam int unsigned NSQRT = Q_W / 2;

  logic             gamma_q;
  logic [CNT_W-1:0] count_q;
  logic             en;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= 1'b1;
      count_q <= CNT_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgGammaEnable: gamma_q <= cfg_data_i[0];
        CfgSampleCount: count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the row unless the output holds an untaken item
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Entry stage: clamp the count, flag saturation, form the linear byte
  div_stage_t div_s [NDIV+1];
  div_stage_t entry_d;
  div_stage_t entry_q;
  always_comb begin
    logic [CNT_W-1:0]     n;
    logic [SUM_W-1:0]     s [NUM_CH];
    logic [CNT_W+Q_W-1:0] lim;
    s[0] = in_data_i.red_sum;
    s[1] = in_data_i.green_sum;
    s[2] = in_data_i.blue_sum;
    n = count_q;
    if (n == '0) n = CNT_W'(1);
    if (n > CNT_W'(MAX_SAMPLES)) n = CNT_W'(MAX_SAMPLES);
    lim = {n, {Q_W{1'b0}}};
    entry_d.valid = in_valid_i;
    entry_d.gamma = gamma_q;
    entry_d.dvs   = {n, {(Q_W-1){1'b0}}};
    for (int c = 0; c < NUM_CH; c++) begin
      entry_d.ch[c].rem = s[c];
      entry_d.ch[c].quo = '0;
      entry_d.ch[c].sat = ((CNT_W+Q_W+SUM_W)'(s[c]) >= (CNT_W+Q_W+SUM_W)'(lim));
      if ((s[c] >> R_W) > SUM_W'({R_W{1'b1}})) begin
        entry_d.ch[c].lin = {R_W{1'b1}};
      end else begin
        entry_d.ch[c].lin = s[c][2*R_W-1:R_W];
      end
    end
  end

  // Capture the entry stage; clear it under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (en) begin
      entry_q <= entry_d;
    end
  end

  assign div_s[0] = entry_q;

  // Divider row
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    gcq_div_cell u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (div_s[k]),
      .stage_o (div_s[k+1])
    );
  end

  // Hand quotient to the square root row
  sqrt_stage_t sqrt_s [NSQRT+1];
  sqrt_stage_t sqrt_entry;
  always_comb begin
    sqrt_entry.valid = div_s[NDIV].valid;
    sqrt_entry.gamma = div_s[NDIV].gamma;
    sqrt_entry.bitm  = Q_W'(1) << (Q_W - 2);
    for (int c = 0; c < NUM_CH; c++) begin
      sqrt_entry.ch[c].rad  = div_s[NDIV].ch[c].quo;
      sqrt_entry.ch[c].root = '0;
      sqrt_entry.ch[c].sat  = div_s[NDIV].ch[c].sat;
      sqrt_entry.ch[c].lin  = div_s[NDIV].ch[c].lin;
    end
  end

  assign sqrt_s[0] = sqrt_entry;

  for (genvar k = 0; k < NSQRT; k++) begin : g_sqrt
    gcq_sqrt_cell u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (sqrt_s[k]),
      .stage_o (sqrt_s[k+1])
    );
  end

  // Select the channel byte per mode
  logic [R_W-1:0] byte_d [NUM_CH];
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (!sqrt_s[NSQRT].gamma) begin
        byte_d[c] = sqrt_s[NSQRT].ch[c].lin;
      end else if (sqrt_s[NSQRT].ch[c].sat) begin
        byte_d[c] = {R_W{1'b1}};
      end else begin
        byte_d[c] = sqrt_s[NSQRT].ch[c].root[R_W-1:0];
      end
    end
  end

  // Output register
  logic     out_valid_q;
  pix_out_t out_data_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sqrt_s[NSQRT].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.red_byte   <= byte_d[0];
      out_data_q.green_byte <= byte_d[1];
      out_data_q.blue_byte  <= byte_d[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A stalled result stays valid and unchanged
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The row freezes while the output is stalled
  a_row_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(div_s[0].valid) && $stable(sqrt_s[NSQRT].valid))
    else $error("pipeline moved during stall");

  // Input is refused only while a result waits
  a_ready_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input refused without stall");

endmodule

### tb/tb_top.sv
// Testbench for the gamma color quantizer: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import gcq_pkg::*;

  localparam int unsigned LATENCY   = 26;
  localparam int unsigned IDLE_MAX  = 200000;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam cfg_idx_e CfgIdxUnused = cfg_idx_e'(2'd3);

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i;
  logic [CNT_W-1:0]  cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  pix_in_t           in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  pix_out_t          out_data_o;

  // Predictor copy of the registers
  logic             gamma_on;
  logic [CNT_W-1:0] divisor_reg;

  pix_out_t expected_bytes[$];
  int unsigned errors;
  int unsigned bytes_checked;
  int unsigned idle_cycles;
  bit          quiet_tail;
  int unsigned stall_left;

  gamma_color_quantizer dut (.*);

  // Clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Integer square root, floor
  function automatic logic [31:0] floor_sqrt(input logic [SUM_W-1:0] v);
    logic [31:0] root;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      logic [31:0] trial;
      trial = root | (32'd1 << b);
      if (trial * trial <= {4'd0, v}) root = trial;
    end
    return root;
  endfunction

  function automatic logic [R_W-1:0] channel_byte(input logic [SUM_W-1:0] s);
    logic [31:0] n;
    logic [31:0] r;
    if (gamma_on) begin
      n = 32'(divisor_reg);
      if (n == 0) n = 1;
      if (n > MAX_SAMPLES) n = MAX_SAMPLES;
      r = floor_sqrt(SUM_W'(32'(s) / n));
    end else begin
      r = 32'(s >> 8);
    end
    return (r > 255) ? 8'd255 : r[R_W-1:0];
  endfunction

  function automatic pix_out_t quantize_pixel(input pix_in_t p);
    pix_out_t q;
    q.red_byte   = channel_byte(p.red_sum);
    q.green_byte = channel_byte(p.green_sum);
    q.blue_byte  = channel_byte(p.blue_sum);
    return q;
  endfunction

  // Send one item, with an optional random gap before it; valid stays high after
  task automatic send_pixel(input pix_in_t p);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_data_i  <= p;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_bytes.push_back(quantize_pixel(p));
    @(negedge clk_i);
  endtask

  task automatic send_sums(input logic [SUM_W-1:0] r, g, b);
    pix_in_t p;
    p.red_sum = r;
    p.green_sum = g;
    p.blue_sum = b;
    send_pixel(p);
  endtask

  // Drain then write one register
  task automatic write_reg(input cfg_idx_e idx, input logic [CNT_W-1:0] val);
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgGammaEnable: gamma_on = val[0];
      CfgSampleCount: divisor_reg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [SUM_W-1:0] rand_sum();
    case ($urandom_range(0, 3))
      0: return SUM_W'($urandom_range(0, 65535));
      1: return SUM_MAX - SUM_W'($urandom_range(0, 255));
      default: return SUM_W'($urandom()) & SUM_MAX;
    endcase
  endfunction

  task automatic test_extremes();
    send_sums('0, '0, '0);
    send_sums(SUM_MAX, SUM_MAX, SUM_MAX);
    send_sums(28'h0AAAAAA, 28'h5555555, 28'hA5A5A5A);
    send_sums(28'd65025, 28'd65024, 28'd65536);
    send_sums(28'd255, 28'd256, 28'd65280);
    send_sums(28'd65279, 28'd1, 28'd4);
  endtask

  task automatic test_modes();
    write_reg(CfgGammaEnable, '0);
    test_extremes();
    write_reg(CfgGammaEnable, 13'd1);
    write_reg(CfgSampleCount, '0);        // zero count acts as one
    test_extremes();
    write_reg(CfgSampleCount, 13'd4096);
    test_extremes();
    write_reg(CfgSampleCount, 13'h1FFF);  // above the limit, saturates
    test_extremes();
    write_reg(CfgIdxUnused, 13'd7);       // unknown index, ignored
    send_sums(SUM_MAX, 28'd12345, 28'd0);
  endtask

  task automatic test_random(input int unsigned count);
    for (int i = 0; i < count; i++) send_sums(rand_sum(), rand_sum(), rand_sum());
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CfgGammaEnable, CNT_W'($urandom_range(0, 1)));
      write_reg(CfgSampleCount, CNT_W'($urandom_range(0, 8191)));
      if (ph == 7) quiet_tail = 1'b1;
      test_random(177);
    end
  endtask

  // Random bursts of output stall
  always @(negedge clk_i) begin
    if (quiet_tail) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 18);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        pix_out_t e;
        e = expected_bytes.pop_front();
        bytes_checked++;
        if (out_data_o.red_byte !== e.red_byte)
          $display("%0t: red exp %0d got %0d", $time, e.red_byte, out_data_o.red_byte);
        if (out_data_o.green_byte !== e.green_byte)
          $display("%0t: green exp %0d got %0d", $time, e.green_byte, out_data_o.green_byte);
        if (out_data_o.blue_byte !== e.blue_byte)
          $display("%0t: blue exp %0d got %0d", $time, e.blue_byte, out_data_o.blue_byte);
        if (out_data_o !== e) errors++;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("FAIL gamma_color_quantizer");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgGammaEnable;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    stall_left = 0;
    quiet_tail = 1'b0;
    errors = 0;
    bytes_checked = 0;
    idle_cycles = 0;
    gamma_on = 1'b1;
    divisor_reg = 13'd1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    test_modes();
    test_random_settings();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    $display("Covered linear and gamma modes, sample counts zero to above limit, %0d pixels.",
             bytes_checked);
    if (errors == 0) begin
      $display("PASS gamma_color_quantizer");
    end else begin
      $display("FAIL gamma_color_quantizer");
    end
    $finish;
  end
endmodule
